// ----- src/assert_macros.svh -----
// Assertion macros shared by the radial red boost RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property, sampled on clk and disabled while rst_n is low.
`define RRLB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define RRLB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- src/rrlb_pkg.sv -----
// Types and constants for the radial red boost pipeline.
`default_nettype none
package rrlb_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DIM_W      = 13;
  localparam int GAIN_W     = 16;
  localparam int EXP_W      = 3;
  localparam int M2_W       = 26;
  localparam int VAL_W      = 24;
  localparam int LUMA_W     = 24;
  localparam int NUM_W      = 32;
  localparam int BOOST_W    = 11;
  localparam int POW_STAGES = (1 << EXP_W) - 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_GAIN   = 2'd2,
    CFG_EXP    = 2'd3
  } cfg_idx_t;

  localparam logic [DIM_W-1:0]  WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0]  HEIGHT_RST = 13'd480;
  localparam logic [GAIN_W-1:0] GAIN_RST   = 16'd256;
  localparam logic [EXP_W-1:0]  EXP_RST    = 3'd3;

  localparam logic [15:0] LUMA_CR = 16'd13933;
  localparam logic [15:0] LUMA_CG = 16'd46871;
  localparam logic [15:0] LUMA_CB = 16'd4732;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [GAIN_W-1:0] gain;
    logic [EXP_W-1:0]  expo;
  } cfg_t;

endpackage
`default_nettype wire

// ----- src/rrlb_radius.sv -----
// Normalised radius: distances, restoring divider and digit-by-digit square root.
`default_nettype none
`include "assert_macros.svh"
module rrlb_radius #(
  parameter int COORD_BITS      = 12,
  parameter int RATIO_FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       in_valid,
  input  logic [COORD_BITS-1:0]      px,
  input  logic [COORD_BITS-1:0]      py,
  input  rrlb_pkg::pix_t             in_pix,
  input  rrlb_pkg::cfg_t             cfg,
  output logic                       out_valid,
  output rrlb_pkg::pix_t             out_pix,
  output logic [RATIO_FRAC_BITS-1:0] out_r
);
  import rrlb_pkg::*;

  localparam int F     = RATIO_FRAC_BITS;
  localparam int DW    = (COORD_BITS > 12) ? COORD_BITS : 12;
  localparam int XW    = DW + 1;
  localparam int SQW   = 2 * DW;
  localparam int D2W   = 2 * DW + 1;
  localparam int MQ_W  = M2_W - 1;
  localparam int CW    = (D2W > M2_W) ? D2W : M2_W;
  localparam int DIV_N = 2 * F;
  localparam int SR_W  = F + 2;

  logic [XW-1:0]    px_e, py_e, cx_e, cy_e;
  logic [DW-1:0]    dx_nxt, dy_nxt;
  logic [DIM_W-1:0] mx_nxt, my_nxt;

  always_comb begin
    px_e   = XW'(px);
    py_e   = XW'(py);
    cx_e   = XW'(cfg.width[DIM_W-1:1]);
    cy_e   = XW'(cfg.height[DIM_W-1:1]);
    dx_nxt = DW'((px_e >= cx_e) ? (px_e - cx_e) : (cx_e - px_e));
    dy_nxt = DW'((py_e >= cy_e) ? (py_e - cy_e) : (cy_e - py_e));
    mx_nxt = cfg.width - DIM_W'(cfg.width[DIM_W-1:1]);
    my_nxt = cfg.height - DIM_W'(cfg.height[DIM_W-1:1]);
  end

  logic             a_valid_r;
  logic [DW-1:0]    a_dx_r, a_dy_r;
  logic [DIM_W-1:0] a_mx_r, a_my_r;
  pix_t             a_pix_r;

  logic             b_valid_r;
  logic [SQW-1:0]   b_dx2_r, b_dy2_r;
  logic [MQ_W-1:0]  b_mx2_r, b_my2_r;
  pix_t             b_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_dx_r  <= dx_nxt;
      a_dy_r  <= dy_nxt;
      a_mx_r  <= mx_nxt;
      a_my_r  <= my_nxt;
      a_pix_r <= in_pix;
      b_dx2_r <= SQW'(a_dx_r) * SQW'(a_dx_r);
      b_dy2_r <= SQW'(a_dy_r) * SQW'(a_dy_r);
      b_mx2_r <= MQ_W'(a_mx_r) * MQ_W'(a_mx_r);
      b_my2_r <= MQ_W'(a_my_r) * MQ_W'(a_my_r);
      b_pix_r <= a_pix_r;
    end
  end

  logic [D2W-1:0]  d2;
  logic [M2_W-1:0] m2;
  logic            m2_zero, d2_ge;

  always_comb begin
    d2      = D2W'(b_dx2_r) + D2W'(b_dy2_r);
    m2      = M2_W'(b_mx2_r) + M2_W'(b_my2_r);
    m2_zero = (m2 == '0);
    d2_ge   = CW'(d2) >= CW'(m2);
  end

  logic            dv_valid_r [0:DIV_N];
  logic [M2_W-1:0] dv_rem_r   [0:DIV_N];
  logic [M2_W-1:0] dv_m2_r    [0:DIV_N];
  logic [DIV_N-1:0] dv_q_r    [0:DIV_N];
  logic            dv_sat_r   [0:DIV_N];
  logic            dv_zero_r  [0:DIV_N];
  pix_t            dv_pix_r   [0:DIV_N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_valid_r[0] <= 1'b0;
    end else if (adv) begin
      dv_valid_r[0] <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rem_r[0]  <= M2_W'(d2);
      dv_m2_r[0]   <= m2;
      dv_q_r[0]    <= '0;
      dv_sat_r[0]  <= !m2_zero && d2_ge;
      dv_zero_r[0] <= m2_zero;
      dv_pix_r[0]  <= b_pix_r;
    end
  end

  for (genvar k = 0; k < DIV_N; k++) begin : g_div
    logic [M2_W:0] rem2;
    logic          ge;

    assign rem2 = {dv_rem_r[k], 1'b0};
    assign ge   = rem2 >= {1'b0, dv_m2_r[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_valid_r[k+1] <= 1'b0;
      end else if (adv) begin
        dv_valid_r[k+1] <= dv_valid_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem_r[k+1]  <= ge ? M2_W'(rem2 - {1'b0, dv_m2_r[k]}) : M2_W'(rem2);
        dv_m2_r[k+1]   <= dv_m2_r[k];
        dv_q_r[k+1]    <= {dv_q_r[k][DIV_N-2:0], ge};
        dv_sat_r[k+1]  <= dv_sat_r[k];
        dv_zero_r[k+1] <= dv_zero_r[k];
        dv_pix_r[k+1]  <= dv_pix_r[k];
      end
    end
  end

  logic             sq_valid [0:F];
  logic [DIV_N-1:0] sq_q     [0:F];
  logic [F-1:0]     sq_root  [0:F];
  logic [SR_W-1:0]  sq_rem   [0:F];
  logic             sq_sat   [0:F];
  logic             sq_zero  [0:F];
  pix_t             sq_pix   [0:F];

  assign sq_valid[0] = dv_valid_r[DIV_N];
  assign sq_q[0]     = dv_q_r[DIV_N];
  assign sq_root[0]  = '0;
  assign sq_rem[0]   = '0;
  assign sq_sat[0]   = dv_sat_r[DIV_N];
  assign sq_zero[0]  = dv_zero_r[DIV_N];
  assign sq_pix[0]   = dv_pix_r[DIV_N];

  for (genvar j = 0; j < F; j++) begin : g_sqrt
    logic [SR_W+1:0] rt, trial;
    logic            ge;

    assign rt    = {sq_rem[j], sq_q[j][DIV_N-1 -: 2]};
    assign trial = {SR_W'(sq_root[j]), 2'b01};
    assign ge    = rt >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_valid[j+1] <= 1'b0;
      end else if (adv) begin
        sq_valid[j+1] <= sq_valid[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem[j+1]  <= ge ? SR_W'(rt - trial) : SR_W'(rt);
        sq_root[j+1] <= {sq_root[j][F-2:0], ge};
        sq_q[j+1]    <= sq_q[j] << 2;
        sq_sat[j+1]  <= sq_sat[j];
        sq_zero[j+1] <= sq_zero[j];
        sq_pix[j+1]  <= sq_pix[j];
      end
    end
  end

  always_comb begin
    out_valid = sq_valid[F];
    out_pix   = sq_pix[F];
    if (sq_zero[F]) begin
      out_r = '0;
    end else if (sq_sat[F]) begin
      out_r = '1;
    end else begin
      out_r = sq_root[F];
    end
  end

  `RRLB_ASSERT_IMP(a_div_rem_below_divisor,
    dv_valid_r[DIV_N] && !dv_sat_r[DIV_N] && !dv_zero_r[DIV_N],
    dv_rem_r[DIV_N] < dv_m2_r[DIV_N], "radius divider remainder not below divisor")

endmodule
`default_nettype wire

// ----- src/rrlb_gain.sv -----
// Power of the radius and multiplication by the falloff gain.
`default_nettype none
`include "assert_macros.svh"
module rrlb_gain #(
  parameter int RATIO_FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic [RATIO_FRAC_BITS-1:0]  in_r,
  input  rrlb_pkg::pix_t              in_pix,
  input  rrlb_pkg::cfg_t              cfg,
  output logic                        out_valid,
  output rrlb_pkg::pix_t              out_pix,
  output logic [rrlb_pkg::VAL_W-1:0]  out_val
);
  import rrlb_pkg::*;

  localparam int F    = RATIO_FRAC_BITS;
  localparam int PW   = 2 * F + 1;
  localparam int GP_W = GAIN_W + F + 1;
  localparam logic [F:0] RP_ONE = (F + 1)'(1) << F;

  logic         pw_valid [0:POW_STAGES];
  logic [F:0]   pw_rp    [0:POW_STAGES];
  logic [F-1:0] pw_r     [0:POW_STAGES];
  pix_t         pw_pix   [0:POW_STAGES];

  assign pw_valid[0] = in_valid;
  assign pw_rp[0]    = (cfg.expo == '0) ? RP_ONE : {1'b0, in_r};
  assign pw_r[0]     = in_r;
  assign pw_pix[0]   = in_pix;

  for (genvar s = 0; s < POW_STAGES; s++) begin : g_pow
    logic [PW-1:0] prod;
    logic          use_mul;

    assign prod    = PW'(pw_rp[s]) * PW'(pw_r[s]);
    assign use_mul = EXP_W'(s + 1) < cfg.expo;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pw_valid[s+1] <= 1'b0;
      end else if (adv) begin
        pw_valid[s+1] <= pw_valid[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pw_rp[s+1]  <= use_mul ? (F + 1)'(prod >> F) : pw_rp[s];
        pw_r[s+1]   <= pw_r[s];
        pw_pix[s+1] <= pw_pix[s];
      end
    end
  end

  logic [GP_W-1:0] gp;
  logic            g_valid_r;
  pix_t            g_pix_r;
  logic [VAL_W-1:0] g_val_r;

  assign gp = GP_W'(cfg.gain) * GP_W'(pw_rp[POW_STAGES]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_valid_r <= 1'b0;
    end else if (adv) begin
      g_valid_r <= pw_valid[POW_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_val_r <= gp[F-8 +: VAL_W];
      g_pix_r <= pw_pix[POW_STAGES];
    end
  end

  assign out_valid = g_valid_r;
  assign out_pix   = g_pix_r;
  assign out_val   = g_val_r;

  `RRLB_ASSERT_IMP(a_power_not_above_base,
    pw_valid[POW_STAGES] && (cfg.expo != '0),
    pw_rp[POW_STAGES] <= (F + 1)'(pw_r[POW_STAGES]), "radius power exceeds its base")

endmodule
`default_nettype wire

// ----- src/rrlb_boost.sv -----
// Luma, boost divider and red saturation.
`default_nettype none
`include "assert_macros.svh"
module rrlb_boost (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       in_valid,
  input  rrlb_pkg::pix_t             in_pix,
  input  logic [rrlb_pkg::VAL_W-1:0] in_val,
  output logic                       out_valid,
  output rrlb_pkg::pix_t             out_pix,
  output logic                       out_clip
);
  import rrlb_pkg::*;

  localparam int WW = NUM_W + BOOST_W;
  localparam int SW = BOOST_W + 1;

  logic              dv_valid [0:BOOST_W];
  logic [NUM_W-1:0]  dv_rem   [0:BOOST_W];
  logic [LUMA_W-1:0] dv_luma  [0:BOOST_W];
  logic [BOOST_W-1:0] dv_q    [0:BOOST_W];
  pix_t              dv_pix   [0:BOOST_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_valid[0] <= 1'b0;
    end else if (adv) begin
      dv_valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_luma[0] <= LUMA_W'(LUMA_CR) * LUMA_W'(in_pix.red)
                  + LUMA_W'(LUMA_CG) * LUMA_W'(in_pix.green)
                  + LUMA_W'(LUMA_CB) * LUMA_W'(in_pix.blue);
      dv_rem[0]  <= NUM_W'(in_val) * NUM_W'(in_pix.red);
      dv_q[0]    <= '0;
      dv_pix[0]  <= in_pix;
    end
  end

  for (genvar k = 0; k < BOOST_W; k++) begin : g_div
    logic [WW-1:0] dvs, rem_w;
    logic          ge;

    assign dvs   = WW'(dv_luma[k]) << (BOOST_W - 1 - k);
    assign rem_w = WW'(dv_rem[k]);
    assign ge    = rem_w >= dvs;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_valid[k+1] <= 1'b0;
      end else if (adv) begin
        dv_valid[k+1] <= dv_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem[k+1]  <= ge ? NUM_W'(rem_w - dvs) : dv_rem[k];
        dv_luma[k+1] <= dv_luma[k];
        dv_q[k+1]    <= {dv_q[k][BOOST_W-2:0], ge};
        dv_pix[k+1]  <= dv_pix[k];
      end
    end
  end

  logic [SW-1:0] sum;
  logic          luma_zero, clip_nxt;
  pix_t          pix_nxt;

  always_comb begin
    sum       = SW'(dv_pix[BOOST_W].red) + SW'(dv_q[BOOST_W]);
    luma_zero = (dv_luma[BOOST_W] == '0);
    clip_nxt  = !luma_zero && (sum > SW'(255));
    pix_nxt   = dv_pix[BOOST_W];
    if (clip_nxt) begin
      pix_nxt.red = 8'hFF;
    end else if (!luma_zero) begin
      pix_nxt.red = sum[7:0];
    end
  end

  logic o_valid_r, o_clip_r;
  pix_t o_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (adv) begin
      o_valid_r <= dv_valid[BOOST_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_pix_r  <= pix_nxt;
      o_clip_r <= clip_nxt;
    end
  end

  assign out_valid = o_valid_r;
  assign out_pix   = o_pix_r;
  assign out_clip  = o_clip_r;

  `RRLB_ASSERT_IMP(a_boost_rem_below_luma,
    dv_valid[BOOST_W] && !luma_zero,
    dv_rem[BOOST_W] < NUM_W'(dv_luma[BOOST_W]), "boost divider remainder not below luma")
  `RRLB_ASSERT_IMP(a_dark_pixel_no_boost,
    dv_valid[BOOST_W] && luma_zero,
    !clip_nxt && (pix_nxt.red == 8'h00), "black pixel red not passed through")

endmodule
`default_nettype wire

// ----- src/radial_red_luma_boost_top.sv -----
// Top level of the radial red boost: configuration registers and pipeline.
// Throughput: one beat per cycle while the output is not stalled.
// The square-root, divider and power stages are all pipelined.
// A stalled output beat freezes the whole pipeline, and in_stall follows it in that cycle.
// Reset is synchronous and active low; it empties the pipeline and loads the register defaults.
`default_nettype none
module radial_red_luma_boost_top #(
  parameter int COORD_BITS      = 12,
  parameter int RATIO_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [COORD_BITS-1:0]               in_pixel_x,
  input  logic [COORD_BITS-1:0]               in_pixel_y,
  input  logic [7:0]                          in_red_in,
  input  logic [7:0]                          in_green_in,
  input  logic [7:0]                          in_blue_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [7:0]                          out_red_out,
  output logic [7:0]                          out_green_out,
  output logic [7:0]                          out_blue_out,
  output logic                                out_red_clipped,
  input  logic                                cfg_wr_en,
  input  logic [rrlb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rrlb_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rrlb_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WIDTH:  cfg_nxt.width  = cfg_data[DIM_W-1:0];
        CFG_HEIGHT: cfg_nxt.height = cfg_data[DIM_W-1:0];
        CFG_GAIN:   cfg_nxt.gain   = cfg_data[GAIN_W-1:0];
        CFG_EXP:    cfg_nxt.expo   = cfg_data[EXP_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{width: WIDTH_RST, height: HEIGHT_RST, gain: GAIN_RST, expo: EXP_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  logic adv;
  pix_t in_pix;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign in_pix   = {in_red_in, in_green_in, in_blue_in};

  logic                       rad_valid;
  pix_t                       rad_pix;
  logic [RATIO_FRAC_BITS-1:0] rad_r;

  rrlb_radius #(
    .COORD_BITS      (COORD_BITS),
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_radius (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .px        (in_pixel_x),
    .py        (in_pixel_y),
    .in_pix    (in_pix),
    .cfg       (cfg_r),
    .out_valid (rad_valid),
    .out_pix   (rad_pix),
    .out_r     (rad_r)
  );

  logic             gn_valid;
  pix_t             gn_pix;
  logic [VAL_W-1:0] gn_val;

  rrlb_gain #(
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_gain (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (rad_valid),
    .in_r      (rad_r),
    .in_pix    (rad_pix),
    .cfg       (cfg_r),
    .out_valid (gn_valid),
    .out_pix   (gn_pix),
    .out_val   (gn_val)
  );

  pix_t bst_pix;

  rrlb_boost u_boost (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (gn_valid),
    .in_pix    (gn_pix),
    .in_val    (gn_val),
    .out_valid (out_valid),
    .out_pix   (bst_pix),
    .out_clip  (out_red_clipped)
  );

  assign out_red_out   = bst_pix.red;
  assign out_green_out = bst_pix.green;
  assign out_blue_out  = bst_pix.blue;

endmodule
`default_nettype wire
